// ===== sv/fixed_slot_pool_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Slot pool allocator assertion macros
// Shorthand for clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FSPA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot pool allocator check failed");

// Next-cycle implication, disabled during reset
`define FSPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot pool allocator check failed");

`endif

// ===== sv/fspa_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Pool geometry, field widths, status codes and transaction payload types.
// ----------------------------------------------------------------------------
package fspa_pkg;

  // Pool geometry; SLOT_BYTES must be a power of two (1 to 4096)
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_BYTES = 64;

  localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Field widths
  localparam int OFFSET_W     = 32;
  localparam int STATUS_W     = 3;
  localparam int SLOT_INDEX_W = 4;
  localparam int FREE_COUNT_W = 5;

  localparam logic [OFFSET_W-1:0] POOL_BYTES = OFFSET_W'(SLOT_COUNT * SLOT_BYTES);
  localparam logic [OFFSET_W-1:0] ALIGN_MASK = OFFSET_W'(SLOT_BYTES - 1);

  // Request actions
  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_NULL       = 3'd3,
    ST_OUTSIDE    = 3'd4
  } status_t;

  typedef struct packed {
    action_t                     action;
    logic                        free_null;
    logic signed [OFFSET_W-1:0]  free_offset;
  } req_t;

  typedef struct packed {
    status_t                     status;
    logic [SLOT_INDEX_W-1:0]     slot_index;
    logic [FREE_COUNT_W-1:0]     free_count;
  } rsp_t;

endpackage

// ===== sv/fspa_req_if.sv =====
// ----------------------------------------------------------------------------
// Slot pool request channel
// Valid/ready channel carrying allocate and free requests.
// ----------------------------------------------------------------------------
interface fspa_req_if;
  import fspa_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== sv/fspa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Slot pool response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface fspa_rsp_if;
  import fspa_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== sv/fixed_slot_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed slot pool allocator
// First-fit allocator over a pool of equal slots with a used mark per slot.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                                  Rule
//   req      in   action, free_null, free_offset           taken on valid & ready
//   rsp      out  status, slot_index, free_count           taken on valid & ready
//
// One transaction per cycle sustained while rsp is ready. The request
// register loads at the accepting edge and the result register loads from
// it when rsp is empty or ready, so the result is on rsp from that register.
// The first-fit encoder and the free counter update are combinational
// between those two registers.
// Synchronous reset marks every slot free and empties both registers.
// A stalled rsp holds the result; req stays ready while the request
// register is empty or can move forward in the same cycle.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator (
  input logic         clk,
  input logic         rst,
  fspa_req_if.sink    req,
  fspa_rsp_if.source  rsp
);
  import fspa_pkg::*;

  // Request register
  logic             s1_valid;
  req_t             s1_data;
  logic             s1_adv;

  // Slot state
  logic [SLOT_COUNT-1:0] slot_used;
  logic [SLOT_COUNT-1:0] slot_used_next;
  logic [CNT_W-1:0]      free_cnt;
  logic [CNT_W-1:0]      free_cnt_next;

  // Result register
  logic             out_valid;
  rsp_t             out_data;
  rsp_t             res;

  // Decode helpers
  logic                 alloc_hit;
  logic [IDX_W-1:0]     alloc_idx;
  logic [OFFSET_W-1:0]  off_raw;
  logic [OFFSET_W-1:0]  off_slot;
  logic [IDX_W-1:0]     free_idx;
  logic                 off_outside;
  logic                 off_misaligned;
  logic [IDX_W-1:0]     res_idx;

  // Handshake
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Lowest-numbered free slot
  always_comb begin
    alloc_hit = 1'b0;
    alloc_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        alloc_hit = 1'b1;
        alloc_idx = IDX_W'(i);
      end
    end
  end

  // Offset checks; slot size is a power of two so the slot is a shift
  assign off_raw        = $unsigned(s1_data.free_offset);
  assign off_outside    = off_raw[OFFSET_W-1] || (off_raw >= POOL_BYTES);
  assign off_misaligned = (off_raw & ALIGN_MASK) != '0;
  assign off_slot       = off_raw >> SLOT_SHIFT;
  assign free_idx       = off_slot[IDX_W-1:0];

  // Request evaluation and state update
  always_comb begin
    slot_used_next = slot_used;
    free_cnt_next  = free_cnt;
    res_idx        = '0;
    res.status     = ST_OK;
    priority if (s1_data.action == ACT_ALLOC) begin
      if (alloc_hit) begin
        slot_used_next[alloc_idx] = 1'b1;
        free_cnt_next             = free_cnt - CNT_W'(1);
        res_idx                   = alloc_idx;
      end else begin
        res.status = ST_FULL;
      end
    end else if (s1_data.free_null) begin
      res.status = ST_NULL;
    end else if (off_outside) begin
      res.status = ST_OUTSIDE;
    end else if (off_misaligned) begin
      res.status = ST_MISALIGNED;
    end else begin
      // double free is accepted; count only moves if the slot was in use
      slot_used_next[free_idx] = 1'b0;
      if (slot_used[free_idx]) begin
        free_cnt_next = free_cnt + CNT_W'(1);
      end
      res_idx = free_idx;
    end
    res.slot_index = SLOT_INDEX_W'(res_idx);
    res.free_count = FREE_COUNT_W'(free_cnt_next);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      slot_used <= '0;
      free_cnt  <= CNT_W'(SLOT_COUNT);
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        slot_used <= slot_used_next;
        free_cnt  <= free_cnt_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_data <= req.data;
    end
    if (s1_adv) begin
      out_data <= res;
    end
  end

endmodule

// ===== sv/fspa_checker.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator checker
// Port-level checks on results, bound to the allocator top level.
// ----------------------------------------------------------------------------
`include "fixed_slot_pool_allocator_macros.svh"

module fspa_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input fspa_pkg::rsp_t  rsp_data
);
  import fspa_pkg::*;

  logic rsp_stall;
  logic rsp_fail;
  logic rsp_full;

  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_fail  = rsp_valid && (rsp_data.status != ST_OK);
  assign rsp_full  = rsp_valid && (rsp_data.status == ST_FULL);

  // A stalled result holds its value
  `FSPA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp_data))

  // Any failed request reports slot zero
  `FSPA_ASSERT_NOW(a_fail_idx, clk, rst, rsp_fail, rsp_data.slot_index == '0)

  // A full pool reports no free slots
  `FSPA_ASSERT_NOW(a_full_cnt, clk, rst, rsp_full, rsp_data.free_count == '0)

  // The free count never exceeds the pool size
  `FSPA_ASSERT_NOW(a_cnt_range, clk, rst, rsp_valid, rsp_data.free_count <= FREE_COUNT_W'(SLOT_COUNT))

  // With no result waiting the request side is always open
  `FSPA_ASSERT_NOW(a_req_ready, clk, rst, !rsp_valid, req_ready)

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Slot pool allocator testbench
// A directed sequence fills the pool, frees slots and hits each free error.
// Random traffic then follows, mostly allocates and aligned frees with some
// malformed frees. A scoreboard tracks the used mark of every slot, predicts
// each result and compares it field by field. Both channels stall at random,
// and once the result side holds off long enough to back up the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import fspa_pkg::*;

// Tracks slot ownership and the queue of results still owed by the block
class pool_scoreboard;
  bit [SLOT_COUNT-1:0] slot_used;
  rsp_t                owed_results[$];
  int                  errors;
  int                  results_checked;

  function new();
    slot_used       = '0;
    errors          = 0;
    results_checked = 0;
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Apply one accepted request to the slot marks and queue its result
  function void note_request(req_t r);
    rsp_t        e;
    logic [31:0] raw;
    longint      pool_limit;
    int          i;
    int          n;
    bit          found;

    pool_limit   = longint'(SLOT_COUNT) * longint'(SLOT_BYTES);
    raw          = r.free_offset;
    e.status     = ST_OK;
    e.slot_index = '0;
    found        = 0;

    if (r.action == ACT_ALLOC) begin
      // first fit: lowest free slot
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (!found && !slot_used[i]) begin
          slot_used[i] = 1'b1;
          e.slot_index = SLOT_INDEX_W'(i);
          found        = 1;
        end
      end
      if (!found) e.status = ST_FULL;
    end else if (r.free_null) begin
      e.status = ST_NULL;
    end else if (raw[31] || longint'(raw) >= pool_limit) begin
      e.status = ST_OUTSIDE;
    end else if ((raw % SLOT_BYTES) != 0) begin
      e.status = ST_MISALIGNED;
    end else begin
      // no double-free check: the slot simply ends up free
      i            = int'(raw / SLOT_BYTES);
      slot_used[i] = 1'b0;
      e.slot_index = SLOT_INDEX_W'(i);
    end

    n = 0;
    for (i = 0; i < SLOT_COUNT; i++) if (!slot_used[i]) n++;
    e.free_count = FREE_COUNT_W'(n);
    owed_results.push_back(e);
  endfunction

  // Compare one accepted result with the oldest owed result
  task check_result(rsp_t got);
    rsp_t e;
    results_checked++;
    if (owed_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing owed: status %0d slot %0d count %0d",
                                got.status, got.slot_index, got.free_count));
    end else begin
      e = owed_results.pop_front();
      if (got.status !== e.status)
        report_mismatch($sformatf("status got %0d exp %0d", got.status, e.status));
      if (got.slot_index !== e.slot_index)
        report_mismatch($sformatf("slot_index got %0d exp %0d",
                                  got.slot_index, e.slot_index));
      if (got.free_count !== e.free_count)
        report_mismatch($sformatf("free_count got %0d exp %0d",
                                  got.free_count, e.free_count));
    end
  endtask
endclass

module tb;
  localparam int RANDOM_ITEMS = 450;

  logic clk;
  logic rst;
  bit   rsp_hold;
  bit   hold_done;

  fspa_req_if req_ch ();
  fspa_rsp_if rsp_ch ();

  pool_scoreboard sb = new();

  fixed_slot_pool_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
      if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || rsp_hold) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic req_t make_req(action_t a, logic nul, logic [31:0] off);
    req_t r;
    r.action      = a;
    r.free_null   = nul;
    r.free_offset = off;
    return r;
  endfunction

  // Entered and left at a falling edge
  task automatic send_request(req_t r, bit quiet);
    int gap;
    gap = pick_gap(quiet);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.data  = r;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Random request: mostly allocates and aligned frees, some malformed frees
  function automatic req_t random_request(int alloc_pct);
    int          r;
    logic [31:0] off;
    r = $urandom_range(0, 99);
    if (r < alloc_pct)
      return make_req(ACT_ALLOC, 1'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      off = $urandom_range(0, SLOT_COUNT - 1) * SLOT_BYTES;
      return make_req(ACT_FREE, 1'b0, off);
    end
    if (r < 78)
      return make_req(ACT_FREE, 1'b1, $urandom);
    if (r < 85)
      return make_req(ACT_FREE, 1'b0, $urandom | 32'h8000_0000);
    if (r < 90)
      return make_req(ACT_FREE, 1'b0,
                      $urandom_range(SLOT_COUNT * SLOT_BYTES, 32'h7FFF_FFFF));
    off = $urandom_range(0, SLOT_COUNT - 1) * SLOT_BYTES
          + $urandom_range(1, SLOT_BYTES - 1);
    return make_req(ACT_FREE, 1'b0, off);
  endfunction

  // Result side: random stalls, calm windows, one long hold-off
  initial begin
    int stall_left;
    int cyc;
    int i;
    stall_left = 0;
    cyc        = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      cyc++;
      if (!hold_done && sb.results_checked >= 80) begin
        rsp_hold     = 1'b1;
        rsp_ch.ready = 1'b0;
        for (i = 0; i < 120; i++) @(negedge clk);
        rsp_hold  = 1'b0;
        hold_done = 1'b1;
      end
      if ((cyc % 300) < 60) begin
        rsp_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if ($urandom_range(0, 99) < 25)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int k;
    int waited;
    bit quiet;

    @(negedge rst);
    @(negedge clk);

    // fill the pool; one allocate carries a null flag and junk offset
    send_request(make_req(ACT_ALLOC, 1'b1, 32'hFFFF_FFFF), 0);
    for (k = 1; k < SLOT_COUNT; k++)
      send_request(make_req(ACT_ALLOC, 1'b0, 32'h0), 0);
    // pool full
    send_request(make_req(ACT_ALLOC, 1'b0, 32'h0), 0);
    // null wins over a valid offset
    send_request(make_req(ACT_FREE, 1'b1, 32'h0), 0);
    // outside: negative extremes, just past the end and the largest positive
    send_request(make_req(ACT_FREE, 1'b0, 32'hFFFF_FFFF), 0);
    send_request(make_req(ACT_FREE, 1'b0, 32'h8000_0000), 0);
    send_request(make_req(ACT_FREE, 1'b0, SLOT_COUNT * SLOT_BYTES), 0);
    send_request(make_req(ACT_FREE, 1'b0, 32'h7FFF_FFFF), 0);
    // misaligned at both ends of the pool
    send_request(make_req(ACT_FREE, 1'b0, 32'h1), 0);
    send_request(make_req(ACT_FREE, 1'b0, SLOT_COUNT * SLOT_BYTES - 1), 0);
    // free the last slot, then free it again
    send_request(make_req(ACT_FREE, 1'b0, (SLOT_COUNT - 1) * SLOT_BYTES), 0);
    send_request(make_req(ACT_FREE, 1'b0, (SLOT_COUNT - 1) * SLOT_BYTES), 0);
    send_request(make_req(ACT_FREE, 1'b0, 32'h0), 0);

    // random traffic; the allocate share swings so the pool fills and drains
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = ((k / 40) % 4) == 1;
      send_request(random_request(((k / 50) % 2) ? 30 : 75), quiet);
    end
    req_ch.valid = 1'b0;
    req_ch.data  = '0;

    // drain owed results, bounded
    waited = 0;
    while (sb.owed_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (sb.owed_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.owed_results.size()));

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
